// File: src/tbpc_pkg.sv
package tbpc_pkg;

  // Group geometry
  localparam int GroupSlots = 16;
  localparam int SlotW      = $clog2(GroupSlots);
  localparam int CountW     = SlotW + 1;

  // Pixel values with a class of their own
  localparam logic [31:0] WHITE_PIXEL = 32'hffff_ffff;
  localparam logic [31:0] BLACK_PIXEL = 32'h0000_0000;

  // 2-bit pixel classes
  localparam logic [1:0] CLS_WHITE = 2'b00;
  localparam logic [1:0] CLS_BLACK = 2'b10;
  localparam logic [1:0] CLS_COLOR = 2'b11;

  typedef struct packed {
    logic [31:0] pixel;
    logic        image_end;
  } pix_t;

  typedef struct packed {
    logic [31:0] word;
    logic        is_code;
    logic        run_last;
    logic        stream_end;
  } res_t;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_CODE,
    ST_READ,
    ST_DATA
  } state_t;

endpackage

// File: src/tbpc_ram.sv
module tbpc_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port; rdata holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/two_bit_pixel_class_encoder_top.sv
// Channel | Dir | Handshake             | Payload
// pix     | in  | pix_valid / pix_stall | tbpc_pkg::pix_t (pixel, image_end)
// res     | out | res_valid / res_stall | tbpc_pkg::res_t (word, is_code, run_last, stream_end)
//
// A pixel that does not close a group is taken in ST_ACCEPT, which stays ready for the next.
// A pixel that closes a group (16th slot or image_end) is taken in, then ST_CODE sends the
// code word, then each buffered colored pixel passes through ST_READ, for the registered
// read of the pixel buffer RAM, and ST_DATA, which sends it.
// Output stalls hold ST_CODE and ST_DATA; input is stalled while a group drains.
// Synchronous reset empties the group; the buffer RAM is not cleared.
module two_bit_pixel_class_encoder_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           pix_valid,
  output logic           pix_stall,
  input  tbpc_pkg::pix_t pix,
  output logic           res_valid,
  input  logic           res_stall,
  output tbpc_pkg::res_t res
);

  localparam int SlotW  = tbpc_pkg::SlotW;
  localparam int CountW = tbpc_pkg::CountW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(tbpc_pkg::GroupSlots - 1);

  tbpc_pkg::state_t   state, state_next;
  logic [31:0]        code_accum, code_accum_next;
  logic [SlotW-1:0]   slot_count, slot_count_next;
  logic [CountW-1:0]  color_count, color_count_next;
  logic [SlotW-1:0]   rd_idx, rd_idx_next;
  logic               end_flag, end_flag_next;
  logic               res_valid_next;
  tbpc_pkg::res_t     res_next;

  logic               out_free;
  logic [1:0]         cls;
  logic [31:0]        code_bits;
  logic               ram_we;
  logic               ram_re;
  logic [31:0]        ram_rdata;
  logic               rd_last;

  // Colored pixel buffer
  tbpc_ram #(
    .Width (32),
    .Depth (tbpc_pkg::GroupSlots)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (color_count[SlotW-1:0]),
    .wdata (pix.pixel),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // Pixel class and its position in the code word
  always_comb begin
    if (pix.pixel == tbpc_pkg::WHITE_PIXEL) begin
      cls = tbpc_pkg::CLS_WHITE;
    end else if (pix.pixel == tbpc_pkg::BLACK_PIXEL) begin
      cls = tbpc_pkg::CLS_BLACK;
    end else begin
      cls = tbpc_pkg::CLS_COLOR;
    end
  end

  assign code_bits = {cls, 30'b0} >> {slot_count, 1'b0};
  assign out_free  = !res_valid || !res_stall;
  assign pix_stall = (state != tbpc_pkg::ST_ACCEPT);
  assign rd_last   = ({1'b0, rd_idx} + CountW'(1)) == color_count;

  // Next state and outputs
  always_comb begin
    state_next       = state;
    code_accum_next  = code_accum;
    slot_count_next  = slot_count;
    color_count_next = color_count;
    rd_idx_next      = rd_idx;
    end_flag_next    = end_flag;
    res_valid_next   = res_valid;
    res_next         = res;
    ram_we           = 1'b0;
    ram_re           = 1'b0;

    // output transfer frees the register
    if (res_valid && !res_stall) begin
      res_valid_next = 1'b0;
    end

    case (state)
      tbpc_pkg::ST_ACCEPT: begin
        if (pix_valid) begin
          code_accum_next = code_accum | code_bits;
          slot_count_next = slot_count + SlotW'(1);
          if (cls == tbpc_pkg::CLS_COLOR) begin
            ram_we           = 1'b1;
            color_count_next = color_count + CountW'(1);
          end
          if (slot_count == LastSlot || pix.image_end) begin
            end_flag_next = pix.image_end;
            state_next    = tbpc_pkg::ST_CODE;
          end
        end
      end
      tbpc_pkg::ST_CODE: begin
        if (out_free) begin
          res_valid_next      = 1'b1;
          res_next.word       = code_accum;
          res_next.is_code    = 1'b1;
          res_next.run_last   = (color_count == '0);
          res_next.stream_end = end_flag && (color_count == '0);
          rd_idx_next         = '0;
          if (color_count == '0) begin
            code_accum_next  = '0;
            slot_count_next  = '0;
            color_count_next = '0;
            state_next       = tbpc_pkg::ST_ACCEPT;
          end else begin
            state_next = tbpc_pkg::ST_READ;
          end
        end
      end
      tbpc_pkg::ST_READ: begin
        ram_re     = 1'b1;
        state_next = tbpc_pkg::ST_DATA;
      end
      tbpc_pkg::ST_DATA: begin
        if (out_free) begin
          res_valid_next      = 1'b1;
          res_next.word       = ram_rdata;
          res_next.is_code    = 1'b0;
          res_next.run_last   = rd_last;
          res_next.stream_end = end_flag && rd_last;
          if (rd_last) begin
            code_accum_next  = '0;
            slot_count_next  = '0;
            color_count_next = '0;
            state_next       = tbpc_pkg::ST_ACCEPT;
          end else begin
            rd_idx_next = rd_idx + SlotW'(1);
            state_next  = tbpc_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_next = tbpc_pkg::ST_ACCEPT;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tbpc_pkg::ST_ACCEPT;
      code_accum  <= '0;
      slot_count  <= '0;
      color_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      code_accum  <= code_accum_next;
      slot_count  <= slot_count_next;
      color_count <= color_count_next;
      res_valid   <= res_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx   <= rd_idx_next;
    end_flag <= end_flag_next;
    res      <= res_next;
  end

`ifndef SYNTH
  // Colored pixels never outnumber the pixels of the open group
  a_color_le_slot: assert property (@(posedge clk) disable iff (rst)
    (state == tbpc_pkg::ST_ACCEPT) |-> (color_count <= {1'b0, slot_count}))
    else $error("color count exceeds slot count");

  // A pixel that closes a group starts the drain
  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix_stall && (slot_count == LastSlot || pix.image_end))
    |=> (state == tbpc_pkg::ST_CODE))
    else $error("group close did not start drain");

  // Buffered pixels are sent as raw words
  a_data_raw: assert property (@(posedge clk) disable iff (rst)
    (state == tbpc_pkg::ST_DATA && out_free) |=> (res_valid && !res.is_code))
    else $error("buffered pixel not sent as raw word");

  // Stream end only on the last word of an item
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.stream_end) |-> res.run_last)
    else $error("stream end without run last");
`endif

endmodule

// File: sim/tb_two_bit_pixel_class_encoder_top.sv
`timescale 1ns / 1ps

module tb_two_bit_pixel_class_encoder_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;

  logic           clk;
  logic           rst;
  logic           pix_valid;
  logic           pix_stall;
  tbpc_pkg::pix_t pix;
  logic           res_valid;
  logic           res_stall;
  tbpc_pkg::res_t res;

  // Encoder group state, mirrored
  logic [31:0] grp_code;
  int          grp_slots;
  logic [31:0] color_buf [tbpc_pkg::GroupSlots];
  int          color_cnt;

  tbpc_pkg::res_t expected_words [$];
  int             mismatch_count;
  int             cycle_count;
  int             send_idle_pct;
  int             recv_idle_pct;

  two_bit_pixel_class_encoder_top DUT (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #1 clk = ~clk;

  // Classify one accepted pixel; queue the words of a closed group
  task automatic class_encode_pixel(input tbpc_pkg::pix_t p);
    logic [1:0]     cls;
    tbpc_pkg::res_t r;
    if (p.pixel == tbpc_pkg::WHITE_PIXEL) begin
      cls = tbpc_pkg::CLS_WHITE;
    end else if (p.pixel == tbpc_pkg::BLACK_PIXEL) begin
      cls = tbpc_pkg::CLS_BLACK;
    end else begin
      cls = tbpc_pkg::CLS_COLOR;
      color_buf[color_cnt[tbpc_pkg::SlotW-1:0]] = p.pixel;
      color_cnt++;
    end
    // slot s fills bits 31-2s and 30-2s
    grp_code = grp_code | ({cls, 30'b0} >> (2 * grp_slots));
    grp_slots++;
    if (grp_slots == tbpc_pkg::GroupSlots || p.image_end) begin
      r.word       = grp_code;
      r.is_code    = 1'b1;
      r.run_last   = (color_cnt == 0);
      r.stream_end = r.run_last & p.image_end;
      expected_words.push_back(r);
      for (int k = 0; k < color_cnt; k++) begin
        r.word       = color_buf[k[tbpc_pkg::SlotW-1:0]];
        r.is_code    = 1'b0;
        r.run_last   = (k == color_cnt - 1);
        r.stream_end = r.run_last & p.image_end;
        expected_words.push_back(r);
      end
      grp_code  = '0;
      grp_slots = 0;
      color_cnt = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // One pixel transfer, with random idle cycles ahead of it
  task automatic send_pixel(input logic [31:0] value, input logic last);
    tbpc_pkg::pix_t p;
    p.pixel     = value;
    p.image_end = last;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= p;
    do @(posedge clk); while (pix_stall !== 1'b0);
    class_encode_pixel(p);
  endtask

  // Sender goes idle so the last pixel is not taken twice
  task automatic wait_drained();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] colored_pixel();
    logic [31:0] v;
    v = $urandom;
    if (v == tbpc_pkg::WHITE_PIXEL || v == tbpc_pkg::BLACK_PIXEL) v = 32'h1234_5678;
    return v;
  endfunction

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(9))
      0, 1, 2: return tbpc_pkg::WHITE_PIXEL;
      3, 4, 5: return tbpc_pkg::BLACK_PIXEL;
      // one bit off an extreme
      6:       return ($urandom_range(1) ? tbpc_pkg::WHITE_PIXEL : tbpc_pkg::BLACK_PIXEL)
                      ^ (32'h1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  // One-pixel images of each class
  task automatic test_single_pixel_images();
    send_pixel(tbpc_pkg::WHITE_PIXEL, 1'b1);
    send_pixel(tbpc_pkg::BLACK_PIXEL, 1'b1);
    send_pixel(32'h0000_0001, 1'b1);
  endtask

  // Partial group: the unused slots stay white
  task automatic test_partial_group();
    send_pixel(tbpc_pkg::WHITE_PIXEL, 1'b0);
    send_pixel(tbpc_pkg::BLACK_PIXEL, 1'b0);
    send_pixel(32'h0000_0001, 1'b0);
    send_pixel(32'hffff_fffe, 1'b0);
    send_pixel(32'h8000_0000, 1'b0);
    send_pixel(32'h7fff_ffff, 1'b1);
  endtask

  // Full group of colored pixels gives the longest burst; hold off until it drains
  task automatic test_full_color_group();
    for (int i = 0; i < tbpc_pkg::GroupSlots; i++) send_pixel(colored_pixel(), 1'b0);
    wait_drained();
    send_pixel(tbpc_pkg::BLACK_PIXEL, 1'b1);
  endtask

  // Random images, lengths biased to group boundaries
  task automatic test_random_images(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(4))
        0:       len = $urandom_range(1, 15);
        1:       len = tbpc_pkg::GroupSlots;
        2:       len = 2 * tbpc_pkg::GroupSlots;
        3:       len = $urandom_range(17, 31);
        default: len = $urandom_range(1, 40);
      endcase
      if (len > count - sent) len = count - sent;
      for (int i = 0; i < len; i++) begin
        // an occasional image runs on without its end mark
        send_pixel(rand_pixel(), (i == len - 1) && ($urandom_range(9) != 0));
      end
      sent += len;
    end
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result check
  always @(posedge clk) begin
    tbpc_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", res.word, 32'h0);
      end else begin
        want = expected_words.pop_front();
        if (res.word !== want.word) report_mismatch("word", res.word, want.word);
        if (res.is_code !== want.is_code)
          report_mismatch("is_code", 32'(res.is_code), 32'(want.is_code));
        if (res.run_last !== want.run_last)
          report_mismatch("run_last", 32'(res.run_last), 32'(want.run_last));
        if (res.stream_end !== want.stream_end)
          report_mismatch("stream_end", 32'(res.stream_end), 32'(want.stream_end));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_two_bit_pixel_class_encoder_top: FAIL");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    pix_valid      = 1'b0;
    pix            = '0;
    res_stall      = 1'b0;
    grp_code       = '0;
    grp_slots      = 0;
    color_cnt      = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_idle_pct  = 31;
    recv_idle_pct  = 51;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_pixel_images();
    test_partial_group();
    test_full_color_group();
    test_random_images(65);

    send_idle_pct = 51;
    recv_idle_pct = 31;
    test_random_images(65);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_images(64);

    @(negedge clk);
    pix_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_two_bit_pixel_class_encoder_top: PASS");
    end else begin
      $display("tb_two_bit_pixel_class_encoder_top: FAIL");
    end
    $finish;
  end

endmodule
